// ----- hw/rtl/bkc_pkg.sv -----
// ----------------------------------------------------------------------------
// bkc_pkg
// Shared types and the table of suspicious program names for the basename
// keyword classifier.
// ----------------------------------------------------------------------------
package bkc_pkg;

	localparam int CAP_LEN    = 6;
	localparam int NAME_COUNT = 12;
	localparam int NAME_LEN_W = 3;

	localparam logic [7:0] SLASH = 8'h2F;

	typedef logic [CAP_LEN-1:0][7:0] cap_t;

	localparam logic [7:0] NAME_TEXT [NAME_COUNT][CAP_LEN] = '{
		'{"s", "h", 8'h00, 8'h00, 8'h00, 8'h00},
		'{"b", "a", "s", "h", 8'h00, 8'h00},
		'{"d", "a", "s", "h", 8'h00, 8'h00},
		'{"z", "s", "h", 8'h00, 8'h00, 8'h00},
		'{"k", "s", "h", 8'h00, 8'h00, 8'h00},
		'{"n", "c", 8'h00, 8'h00, 8'h00, 8'h00},
		'{"n", "c", "a", "t", 8'h00, 8'h00},
		'{"s", "o", "c", "a", "t", 8'h00},
		'{"p", "y", "t", "h", "o", "n"},
		'{"p", "e", "r", "l", 8'h00, 8'h00},
		'{"r", "u", "b", "y", 8'h00, 8'h00},
		'{"p", "h", "p", 8'h00, 8'h00, 8'h00}
	};

	localparam logic [NAME_LEN_W-1:0] NAME_LEN [NAME_COUNT] = '{
		3'd2, 3'd4, 3'd4, 3'd3, 3'd3, 3'd2, 3'd4, 3'd5, 3'd6, 3'd4, 3'd4, 3'd3
	};

	localparam logic NAME_PREFIX [NAME_COUNT] = '{
		1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0
	};

endpackage

// ----- hw/rtl/bkc_capture.sv -----
// ----------------------------------------------------------------------------
// bkc_capture
// Byte position, basename start and six-byte capture window. Presents the
// state as it stands after the current byte, and clears it after a path.
// ----------------------------------------------------------------------------
module bkc_capture
	import bkc_pkg::*;
#(
	parameter int BUF_LEN = 64,
	parameter int POS_W   = $clog2(BUF_LEN + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             advance,
	input  logic [7:0]       path_byte,
	input  logic             last_of_path,
	output logic [POS_W-1:0] start_nxt,
	output cap_t             cap_nxt
);

	logic [POS_W-1:0] pos_q;
	logic [POS_W-1:0] start_q;
	cap_t             cap_q;
	logic [POS_W-1:0] pos_nxt;
	logic [POS_W-1:0] diff;

	always_comb begin
		pos_nxt   = pos_q;
		start_nxt = start_q;
		cap_nxt   = cap_q;
		diff      = pos_q - start_q;
		if (pos_q < POS_W'(BUF_LEN)) begin
			if (path_byte == SLASH && pos_q <= POS_W'(BUF_LEN - 2)) begin
				start_nxt = pos_q + POS_W'(1);
				cap_nxt   = '0;
			end else if (pos_q >= start_q) begin
				for (int j = 0; j < CAP_LEN; j++) begin
					if (diff == POS_W'(j)) begin
						cap_nxt[j] = path_byte;
					end
				end
			end
			pos_nxt = pos_q + POS_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			start_q <= '0;
			cap_q   <= '0;
		end else if (advance) begin
			if (last_of_path) begin
				pos_q   <= '0;
				start_q <= '0;
				cap_q   <= '0;
			end else begin
				pos_q   <= pos_nxt;
				start_q <= start_nxt;
				cap_q   <= cap_nxt;
			end
		end
	end

endmodule

// ----- hw/rtl/bkc_match.sv -----
// ----------------------------------------------------------------------------
// bkc_match
// Compares the captured basename bytes and the basename length against the
// fixed table of program names and gives the severity.
// ----------------------------------------------------------------------------
module bkc_match
	import bkc_pkg::*;
#(
	parameter int BUF_LEN = 64,
	parameter int POS_W   = $clog2(BUF_LEN + 1)
) (
	input  cap_t               cap,
	input  logic [POS_W-1:0]   start,
	input  logic signed [7:0]  read_length,
	output logic               severity
);

	logic signed [8:0] blen;
	logic              eq;
	logic              zero_after;
	logic              any_hit;

	always_comb begin
		blen    = 9'(read_length) - $signed(9'(start));
		any_hit = 1'b0;
		for (int k = 0; k < NAME_COUNT; k++) begin
			eq         = 1'b1;
			zero_after = 1'b0;
			for (int j = 0; j < CAP_LEN; j++) begin
				if (NAME_LEN_W'(j) < NAME_LEN[k] && cap[j] != NAME_TEXT[k][j]) begin
					eq = 1'b0;
				end
				if (NAME_LEN_W'(j) == NAME_LEN[k] && cap[j] == 8'h00) begin
					zero_after = 1'b1;
				end
			end
			if (blen >= $signed(9'(NAME_LEN[k])) && eq &&
			    (NAME_PREFIX[k] || blen == $signed(9'(NAME_LEN[k])) || zero_after)) begin
				any_hit = 1'b1;
			end
		end
		severity = any_hit && (read_length > 8'sd1) && (start <= POS_W'(BUF_LEN - 7));
	end

endmodule

// ----- hw/rtl/exec_basename_keyword_classifier.sv -----
// ----------------------------------------------------------------------------
// exec_basename_keyword_classifier
// Classifies the basename of a path, fed one byte per request, against a
// fixed list of suspicious program names.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (byte_valid / byte_stall): one path byte per request, from
//   position 0 upward. last_of_path marks the final byte; read_length is
//   used from that request only.
//   Output channel (sev_valid / sev_stall): one severity per path, none for
//   other bytes.
//   Throughput: one byte per cycle, back to back, unless a final byte
//   waits; set by the single input register stage feeding the capture
//   and match logic. Result: the input register takes the final byte
//   on acceptance, and the result register takes the severity from it.
//   Stall: a held result keeps its value; bytes that are not final still
//   drain, and a final byte waits in the input register, which then raises
//   byte_stall until the result register frees.
//   Reset: clears position, basename start, capture and both valid bits.
// ----------------------------------------------------------------------------
module exec_basename_keyword_classifier
	import bkc_pkg::*;
#(
	parameter int BUF_LEN = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              byte_valid,
	output logic              byte_stall,
	input  logic [7:0]        path_byte,
	input  logic              last_of_path,
	input  logic signed [7:0] read_length,
	output logic              sev_valid,
	input  logic              sev_stall,
	output logic              severity
);

	localparam int POS_W = $clog2(BUF_LEN + 1);

	logic              valid_s1;
	logic [7:0]        byte_s1;
	logic              last_s1;
	logic signed [7:0] rlen_s1;
	logic              go_s1;
	logic              accept;
	logic [POS_W-1:0]  start_nxt;
	cap_t              cap_nxt;
	logic              hit;
	logic              sev_valid_q;
	logic              severity_q;

	assign go_s1      = valid_s1 && (!last_s1 || !sev_valid_q || !sev_stall);
	assign byte_stall = valid_s1 && !go_s1;
	assign accept     = byte_valid && !byte_stall;
	assign sev_valid  = sev_valid_q;
	assign severity   = severity_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (go_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= path_byte;
			last_s1 <= last_of_path;
			rlen_s1 <= read_length;
		end
	end

	bkc_capture #(
		.BUF_LEN(BUF_LEN),
		.POS_W  (POS_W)
	) u_capture (
		.clk         (clk),
		.arst_n      (arst_n),
		.advance     (go_s1),
		.path_byte   (byte_s1),
		.last_of_path(last_s1),
		.start_nxt   (start_nxt),
		.cap_nxt     (cap_nxt)
	);

	bkc_match #(
		.BUF_LEN(BUF_LEN),
		.POS_W  (POS_W)
	) u_match (
		.cap        (cap_nxt),
		.start      (start_nxt),
		.read_length(rlen_s1),
		.severity   (hit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sev_valid_q <= 1'b0;
		end else if (go_s1 && last_s1) begin
			sev_valid_q <= 1'b1;
		end else if (!sev_stall) begin
			sev_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go_s1 && last_s1) begin
			severity_q <= hit;
		end
	end

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Feeds paths byte by byte into exec_basename_keyword_classifier: a short
// table of directed paths first, then random paths with varying idle and
// stall pressure. A local basename tracker predicts the severity of random
// paths and of directed rows that give none, and every severity taken is
// compared with the oldest expectation.
module tb_top;
	import bkc_pkg::*;

	localparam int BUF_LEN     = 64;
	localparam int IDLE_LIMIT  = 2000;
	localparam int HOLD_CYCLES = 150;
	localparam int RAND_ITEMS  = 360;
	localparam int NO_SEV      = -1;

	typedef struct {
		string      head;
		int         pad_count;
		logic [7:0] pad_byte;
		string      tail;
		int         rlen;
		int         sev;
	} path_row_t;

	path_row_t dir_rows [26] = '{
		'{"sh", 0, 8'h00, "", 3, 1},
		'{"/bin/bash", 0, 8'h00, "", 10, 1},
		'{"/x/python3", 0, 8'h00, "", 11, 1},
		'{"/sh", 0, 8'h00, "", 1, 0},
		'{"/sh", 0, 8'h00, "", -64, 0},
		'{"/sh", 0, 8'h00, "", -128, 0},
		'{"sh", 0, 8'h00, "", 127, 1},
		'{"/ab/sh", 0, 8'h00, "", 3, 0},
		'{"", 56, "x", "/sh", 64, 1},
		'{"", 57, "x", "/sh", 64, 0},
		'{"/zsh", 60, 8'h00, "/", 64, 1},
		'{"/ksh", 59, 8'h00, "/", 64, 1},
		'{"sh", 1, 8'hFF, "", 4, 0},
		'{"ncx", 0, 8'h00, "", 4, NO_SEV},
		'{"/", 0, 8'h00, "", 2, NO_SEV},
		'{"dash", 0, 8'h00, "", 5, 1},
		'{"zsh", 0, 8'h00, "", 4, 1},
		'{"ksh", 0, 8'h00, "", 4, 1},
		'{"nc", 0, 8'h00, "", 3, 1},
		'{"ncat", 0, 8'h00, "", 5, 1},
		'{"socat", 0, 8'h00, "", 6, 1},
		'{"python", 0, 8'h00, "", 7, 1},
		'{"perl", 0, 8'h00, "", 5, 1},
		'{"ruby", 0, 8'h00, "", 5, 1},
		'{"php", 0, 8'h00, "", 4, 1},
		'{"/tmp/perlx", 0, 8'h00, "", 11, NO_SEV}
	};

	int idle_plan [4]  = '{0, 61, 0, 21};
	int stall_plan [4] = '{0, 0, 61, 21};

	logic              clk          = 1'b0;
	logic              arst_n       = 1'b0;
	logic              byte_valid   = 1'b0;
	logic              byte_stall;
	logic [7:0]        path_byte    = 8'h00;
	logic              last_of_path = 1'b0;
	logic signed [7:0] read_length  = 8'sd0;
	logic              sev_valid;
	logic              sev_stall    = 1'b0;
	logic              severity;

	logic [6:0] walk_pos;
	logic [6:0] base_start;
	logic [7:0] name_win [CAP_LEN];
	logic       sev_expect_q [$];

	int src_idle_pct   = 0;
	int sink_stall_pct = 0;
	bit long_hold      = 1'b0;
	int mismatches     = 0;
	int errors         = 0;
	int idle_cycles    = 0;
	int fed_items      = 0;

	exec_basename_keyword_classifier #(
		.BUF_LEN(BUF_LEN)
	) u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.byte_valid  (byte_valid),
		.byte_stall  (byte_stall),
		.path_byte   (path_byte),
		.last_of_path(last_of_path),
		.read_length (read_length),
		.sev_valid   (sev_valid),
		.sev_stall   (sev_stall),
		.severity    (severity)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	function automatic void clear_walk();
		walk_pos   = '0;
		base_start = '0;
		foreach (name_win[i]) name_win[i] = 8'h00;
	endfunction

	function automatic logic match_basename(input logic signed [7:0] rl);
		int   blen;
		int   n;
		logic same;
		if (rl <= 1) return 1'b0;
		if (base_start > BUF_LEN - 7) return 1'b0;
		blen = int'(rl) - int'(base_start);
		for (int k = 0; k < NAME_COUNT; k++) begin
			n    = NAME_LEN[k];
			same = 1'b1;
			for (int j = 0; j < n; j++)
				if (name_win[j] != NAME_TEXT[k][j]) same = 1'b0;
			if (blen >= n && same && (NAME_PREFIX[k] || blen == n ||
					(n < CAP_LEN && name_win[n] == 8'h00)))
				return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic logic scan_byte(input logic [7:0] b, input logic lst,
			input logic signed [7:0] rl, output logic sev);
		if (walk_pos < BUF_LEN) begin
			if (b == SLASH && walk_pos <= BUF_LEN - 2) begin
				base_start = walk_pos + 7'd1;
				foreach (name_win[i]) name_win[i] = 8'h00;
			end else if (walk_pos >= base_start && walk_pos - base_start < CAP_LEN) begin
				name_win[walk_pos - base_start] = b;
			end
			walk_pos = walk_pos + 7'd1;
		end
		sev = 1'b0;
		if (!lst) return 1'b0;
		sev = match_basename(rl);
		clear_walk();
		return 1'b1;
	endfunction

	task automatic send_request(input logic [7:0] b, input logic lst,
			input logic signed [7:0] rl, input int forced);
		logic has_sev;
		logic sev;
		while ($urandom_range(99) < src_idle_pct) begin
			byte_valid <= 1'b0;
			@(posedge clk);
		end
		byte_valid   <= 1'b1;
		path_byte    <= b;
		last_of_path <= lst;
		read_length  <= lst ? rl : 8'($urandom);
		do @(posedge clk); while (byte_stall);
		fed_items++;
		has_sev = scan_byte(b, lst, rl, sev);
		if (has_sev) sev_expect_q.push_back(forced < 0 ? sev : forced[0]);
	endtask

	task automatic feed_path(input logic [7:0] bytes_q [$], input int rl, input int forced);
		for (int i = 0; i < bytes_q.size(); i++)
			send_request(bytes_q[i], i == bytes_q.size() - 1, 8'(rl), forced);
	endtask

	task automatic random_path();
		logic [7:0] path_q [$];
		int kind;
		int n;
		int k;
		int rl;
		kind = $urandom_range(9);
		if (kind <= 6) begin
			n = $urandom_range(3);
			repeat (n) begin
				path_q.push_back(SLASH);
				repeat ($urandom_range(1, 5)) path_q.push_back(8'($urandom_range(97, 122)));
			end
			if (n > 0 || $urandom_range(1)) path_q.push_back(SLASH);
			k = $urandom_range(NAME_COUNT);
			if (k == NAME_COUNT) begin
				repeat ($urandom_range(1, 7)) path_q.push_back(8'($urandom_range(97, 122)));
			end else begin
				for (int j = 0; j < NAME_LEN[k]; j++) path_q.push_back(NAME_TEXT[k][j]);
			end
			if ($urandom_range(3) == 0) path_q.push_back(8'($urandom_range(48, 122)));
			if ($urandom_range(5) == 0) path_q[$urandom_range(path_q.size() - 1)] = 8'($urandom);
			rl = path_q.size() + 1;
			case ($urandom_range(5))
				0: rl = $urandom_range(rl);
				1: rl = int'($signed(8'($urandom)));
				default: ;
			endcase
			if ($urandom_range(1)) begin
				path_q.push_back(8'h00);
				repeat ($urandom_range(3)) path_q.push_back(8'($urandom));
			end
		end else if (kind == 7) begin
			n = $urandom_range(48, 62);
			path_q.push_back(SLASH);
			repeat (n - 1) path_q.push_back(8'($urandom_range(97, 122)));
			path_q.push_back(SLASH);
			k = $urandom_range(NAME_COUNT - 1);
			for (int j = 0; j < NAME_LEN[k]; j++) path_q.push_back(NAME_TEXT[k][j]);
			rl = path_q.size() + 1;
			if (rl > BUF_LEN) rl = BUF_LEN;
		end else begin
			n = (kind == 8) ? $urandom_range(1, 70) : $urandom_range(60, 72);
			repeat (n) path_q.push_back(($urandom_range(3) == 0) ? SLASH : 8'($urandom));
			rl = int'($signed(8'($urandom)));
		end
		feed_path(path_q, rl, NO_SEV);
	endtask

	always @(posedge clk) begin
		if ((byte_valid && !byte_stall) || (sev_valid && !sev_stall))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("tb_top: errors");
			$finish;
		end
	end

	initial begin
		int   hold_left;
		logic want_sev;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (sev_valid && !sev_stall) begin
				if (sev_expect_q.size() == 0) begin
					errors++;
					if (mismatches < 10) $display("unexpected severity %0b", severity);
					mismatches++;
				end else begin
					want_sev = sev_expect_q.pop_front();
					if (severity !== want_sev) begin
						errors++;
						if (mismatches < 10)
							$display("severity mismatch: expected %0b, got %0b", want_sev, severity);
						mismatches++;
					end
				end
			end
			if (long_hold) begin
				hold_left = HOLD_CYCLES;
				long_hold = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				sev_stall <= 1'b1;
			end else begin
				sev_stall <= ($urandom_range(99) < sink_stall_pct);
			end
		end
	end

	initial begin
		logic [7:0] path_q [$];
		int target;
		clear_walk();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		src_idle_pct   = 21;
		sink_stall_pct = 21;
		foreach (dir_rows[r]) begin
			path_q.delete();
			for (int i = 0; i < dir_rows[r].head.len(); i++) path_q.push_back(dir_rows[r].head[i]);
			repeat (dir_rows[r].pad_count) path_q.push_back(dir_rows[r].pad_byte);
			for (int i = 0; i < dir_rows[r].tail.len(); i++) path_q.push_back(dir_rows[r].tail[i]);
			feed_path(path_q, dir_rows[r].rlen, dir_rows[r].sev);
		end

		for (int ph = 0; ph < 4; ph++) begin
			// drain before changing pressure
			if (sev_expect_q.size() != 0) begin
				byte_valid <= 1'b0;
				while (sev_expect_q.size() != 0) @(posedge clk);
			end
			src_idle_pct   = idle_plan[ph];
			sink_stall_pct = stall_plan[ph];
			if (ph == 0) long_hold = 1'b1;
			target = fed_items + RAND_ITEMS / 4;
			while (fed_items < target) random_path();
		end

		byte_valid <= 1'b0;
		while (sev_expect_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		if (errors == 0 && sev_expect_q.size() == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

endmodule
